>>> rtl/chm_pkg.sv
// chm_pkg: shared types and constants of the chained hash map.
// No dependencies.
package chm_pkg;

  localparam int unsigned MaxBuckets = 256;
  localparam int unsigned PoolSlots  = 256;
  localparam int unsigned ValueBits  = 32;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 9;
  localparam int unsigned CfgW    = 9;
  localparam int unsigned ValW    = 32;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_MOD,
    S_HEAD_RD,
    S_HEAD_WT,
    S_NODE_RD,
    S_NODE_WT,
    S_ALLOC_WT,
    S_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

>>> rtl/chm_mod.sv
// chm_mod: iterative 64-bit key modulo bucket count, one quotient bit per cycle.
// Depends on chm_pkg.
module chm_mod #(
  parameter int unsigned DivW = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [chm_pkg::KeyW-1:0]      key_i,
  input  logic [DivW-1:0]               div_i,
  output chm_pkg::div_ctl_t             ctl_o,
  output logic [DivW-1:0]               rem_o
);

  localparam int unsigned CntW = $clog2(chm_pkg::KeyW + 1);

  logic [chm_pkg::KeyW-1:0] key_q, key_d;
  logic [DivW:0]            rem_q, rem_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [DivW:0]            trial;

  always_comb begin
    trial  = {rem_q[DivW-1:0], key_q[chm_pkg::KeyW-1]};
    key_d  = key_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      key_d  = key_i;
      rem_d  = '0;
      cnt_d  = CntW'(chm_pkg::KeyW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      key_d = {key_q[chm_pkg::KeyW-2:0], 1'b0};
      if (trial >= {1'b0, div_i}) rem_d = trial - {1'b0, div_i};
      else rem_d = trial;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rem_q <= rem_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.done  = done_q;
  assign rem_o       = rem_q[DivW-1:0];

endmodule

>>> rtl/chained_hash_map.sv
// chained_hash_map: separately chained key/value map in block memories.
// A request word is taken only while the engine is idle. Its result word follows
// setup, the serial key modulo (one bit per cycle), the head read, a read and a
// compare per chain node, allocation after a miss, write-back and result; the unused
// selector goes straight from setup to the result. The next request is taken in the
// cycle after the result is handed to the output register at the earliest; a finished
// result waits in the engine only while the output register still holds an
// unaccepted word. After reset a clearing pass empties the bucket heads and fills
// the free stack before the first word is taken. The user must write the bucket
// count only while no request is in flight; the block itself does not enforce
// this. Depends on chm_pkg, chm_mod.
module chained_hash_map #(
  parameter int unsigned MAX_BUCKETS = chm_pkg::MaxBuckets,
  parameter int unsigned POOL_SLOTS  = chm_pkg::PoolSlots,
  parameter int unsigned VALUE_BITS  = chm_pkg::ValueBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [chm_pkg::FuncW-1:0]   func_i,
  input  logic [chm_pkg::KeyW-1:0]    key_i,
  input  logic [chm_pkg::ValW-1:0]    value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [chm_pkg::StatusW-1:0] status_o,
  output logic [chm_pkg::ValW-1:0]    found_value_o,
  output logic [chm_pkg::CountW-1:0]  entry_count_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [chm_pkg::CfgW-1:0]    cfg_data_i
);

  localparam int unsigned BW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned SW   = $clog2(POOL_SLOTS);
  localparam int unsigned LW   = SW + 1;          // link incl. no-slot code
  localparam int unsigned CW   = $clog2(POOL_SLOTS + 1);
  localparam int unsigned DW   = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned IW   = (BW > SW) ? BW : SW;
  localparam int unsigned CfgW = chm_pkg::CfgW;
  localparam logic [LW-1:0] NoSlot = LW'(POOL_SLOTS);

  // memories
  logic [LW-1:0]              head_mem [MAX_BUCKETS];
  logic [chm_pkg::KeyW-1:0]   key_mem  [POOL_SLOTS];
  logic [VALUE_BITS-1:0]      val_mem  [POOL_SLOTS];
  logic [LW-1:0]              link_mem [POOL_SLOTS];
  logic [SW-1:0]              free_mem [POOL_SLOTS];

  chm_pkg::state_e state_q, state_d;
  logic [CfgW-1:0]            bcnt_q;
  logic [IW:0]                init_q, init_d;
  logic [chm_pkg::FuncW-1:0]  func_q, func_d;
  logic [chm_pkg::KeyW-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0]      val_q, val_d;
  logic [BW-1:0]              bkt_q, bkt_d;
  logic [LW-1:0]              cur_q, cur_d, prev_q, prev_d, tail_q, tail_d;
  logic [LW-1:0]              hit_q, hit_d, hitnx_q, hitnx_d;
  logic [CW:0]                steps_q, steps_d;
  logic [CW-1:0]              free_q, free_d;
  logic [CW-1:0]              held_q, held_d;
  logic [SW-1:0]              alloc_q, alloc_d;
  logic                       ovld_q, ovld_d;
  logic [chm_pkg::StatusW-1:0] ost_q, ost_d;
  logic [chm_pkg::ValW-1:0]   oval_q, oval_d;

  // output word register
  logic [chm_pkg::StatusW-1:0] res_st_q, res_st_d;
  logic [chm_pkg::ValW-1:0]   res_val_q, res_val_d;
  logic [chm_pkg::CountW-1:0] res_cnt_q, res_cnt_d;

  // registered memory reads
  logic [LW-1:0]              head_rd;
  logic [chm_pkg::KeyW-1:0]   key_rd;
  logic [VALUE_BITS-1:0]      val_rd;
  logic [LW-1:0]              link_rd;
  logic [SW-1:0]              free_rd;
  logic [BW-1:0]              head_ra;
  logic [SW-1:0]              node_ra;
  logic [SW-1:0]              free_ra;

  // write strobes
  logic                       head_we, link_we, node_we, free_we;
  logic [BW-1:0]              head_wa;
  logic [LW-1:0]              head_wd;
  logic [SW-1:0]              link_wa, node_wa, free_wa;
  logic [LW-1:0]              link_wd;
  logic [SW-1:0]              free_wd;

  logic                       mod_start;
  chm_pkg::div_ctl_t          mod_ctl;
  logic [DW-1:0]              mod_div, mod_rem;
  logic [CfgW-1:0]            bsat;

  always_comb begin
    bsat = bcnt_q;
    if (bsat == '0) bsat = CfgW'(1);
    if ({{(32-CfgW){1'b0}}, bsat} > MAX_BUCKETS) bsat = CfgW'(MAX_BUCKETS);
    mod_div = DW'(bsat);
  end

  chm_mod #(.DivW(DW)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (key_q),
    .div_i   (mod_div),
    .ctl_o   (mod_ctl),
    .rem_o   (mod_rem)
  );

  assign in_stall_o    = (state_q != chm_pkg::S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = ovld_q;
  assign status_o      = res_st_q;
  assign found_value_o = res_val_q;
  assign entry_count_o = res_cnt_q;

  always_comb begin
    state_d = state_q;
    init_d = init_q;
    func_d = func_q; key_d = key_q; val_d = val_q; bkt_d = bkt_q;
    cur_d = cur_q; prev_d = prev_q; tail_d = tail_q; hit_d = hit_q;
    hitnx_d = hitnx_q; steps_d = steps_q; free_d = free_q; held_d = held_q;
    alloc_d = alloc_q;
    ovld_d = ovld_q && out_stall_i;
    ost_d = ost_q; oval_d = oval_q;
    res_st_d = res_st_q; res_val_d = res_val_q; res_cnt_d = res_cnt_q;
    mod_start = 1'b0;
    head_ra = bkt_q; node_ra = cur_q[SW-1:0]; free_ra = SW'(free_q - 1'b1);
    head_we = 1'b0; head_wa = bkt_q; head_wd = NoSlot;
    link_we = 1'b0; link_wa = '0; link_wd = NoSlot;
    node_we = 1'b0; node_wa = alloc_q;
    free_we = 1'b0; free_wa = '0; free_wd = '0;
    unique case (state_q)
      chm_pkg::S_INIT: begin
        if (init_q < (IW+1)'(MAX_BUCKETS)) begin
          head_we = 1'b1; head_wa = BW'(init_q);
        end
        if (init_q < (IW+1)'(POOL_SLOTS)) begin
          free_we = 1'b1; free_wa = SW'(init_q); free_wd = SW'(init_q);
        end
        init_d = init_q + 1'b1;
        if (init_q >= (IW+1)'(MAX_BUCKETS - 1) && init_q >= (IW+1)'(POOL_SLOTS - 1))
          state_d = chm_pkg::S_IDLE;
      end
      chm_pkg::S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          func_d = func_i; key_d = key_i; val_d = VALUE_BITS'(value_i);
          state_d = chm_pkg::S_MOD;
        end
      end
      chm_pkg::S_MOD: begin
        if (func_q == chm_pkg::FUNC_NONE) begin
          ost_d = chm_pkg::ST_MISS; oval_d = '0;
          state_d = chm_pkg::S_DONE;
        end else begin
          mod_start = 1'b1;
          state_d = chm_pkg::S_HEAD_RD;
        end
      end
      chm_pkg::S_HEAD_RD: begin
        if (mod_ctl.done) begin
          bkt_d = BW'(mod_rem);
          head_ra = BW'(mod_rem);
          state_d = chm_pkg::S_HEAD_WT;
        end
      end
      chm_pkg::S_HEAD_WT: begin
        cur_d = head_rd; prev_d = NoSlot; tail_d = NoSlot; hit_d = NoSlot;
        steps_d = '0;
        node_ra = head_rd[SW-1:0];
        state_d = chm_pkg::S_NODE_RD;
      end
      chm_pkg::S_NODE_RD: begin
        if (cur_q >= NoSlot || steps_q >= (CW+1)'(POOL_SLOTS)) begin
          free_ra = SW'(free_q - 1'b1);
          state_d = chm_pkg::S_ALLOC_WT;
        end else begin
          state_d = chm_pkg::S_NODE_WT;
        end
      end
      chm_pkg::S_NODE_WT: begin
        if (key_rd == key_q) begin
          hit_d = cur_q; hitnx_d = link_rd;
          oval_d = chm_pkg::ValW'(val_rd);
          state_d = chm_pkg::S_WRITE;
        end else begin
          tail_d = cur_q; prev_d = cur_q; cur_d = link_rd;
          node_ra = link_rd[SW-1:0];
          steps_d = steps_q + 1'b1;
          state_d = chm_pkg::S_NODE_RD;
        end
      end
      chm_pkg::S_ALLOC_WT: begin
        alloc_d = free_rd;
        state_d = chm_pkg::S_WRITE;
      end
      chm_pkg::S_WRITE: begin
        ost_d = chm_pkg::ST_MISS;
        if (!(func_q == chm_pkg::FUNC_LOOKUP && hit_q != NoSlot)) oval_d = '0;
        priority case (func_q)
          chm_pkg::FUNC_INSERT: begin
            if (hit_q != NoSlot) begin
              ost_d = chm_pkg::ST_MISS;
            end else if (free_q == '0) begin
              ost_d = chm_pkg::ST_FULL;
            end else begin
              node_we = 1'b1; node_wa = alloc_q;
              link_we = 1'b1; link_wa = alloc_q; link_wd = NoSlot;
              if (tail_q != NoSlot) begin
                free_we = 1'b0;
              end else begin
                head_we = 1'b1; head_wd = {1'b0, alloc_q};
              end
              free_d = free_q - 1'b1;
              held_d = held_q + 1'b1;
              ost_d = chm_pkg::ST_OK;
            end
          end
          chm_pkg::FUNC_DELETE: begin
            if (hit_q != NoSlot) begin
              if (prev_q != NoSlot) begin
                link_we = 1'b1; link_wa = prev_q[SW-1:0]; link_wd = hitnx_q;
              end else begin
                head_we = 1'b1; head_wd = hitnx_q;
              end
              if (free_q < CW'(POOL_SLOTS)) begin
                free_we = 1'b1; free_wa = SW'(free_q); free_wd = hit_q[SW-1:0];
                free_d = free_q + 1'b1;
              end
              if (held_q != '0) held_d = held_q - 1'b1;
              ost_d = chm_pkg::ST_OK;
            end
          end
          default: begin
            if (hit_q != NoSlot) ost_d = chm_pkg::ST_OK;
          end
        endcase
        state_d = chm_pkg::S_DONE;
      end
      chm_pkg::S_DONE: begin
        // tail link fix-up for an insert that appended behind a node
        if (func_q == chm_pkg::FUNC_INSERT && ost_q == chm_pkg::ST_OK && tail_q != NoSlot) begin
          link_we = 1'b1; link_wa = tail_q[SW-1:0]; link_wd = {1'b0, alloc_q};
        end
        // hand over once the output register is free or being emptied
        if (!ovld_q || !out_stall_i) begin
          res_st_d = ost_q;
          res_val_d = oval_q;
          res_cnt_d = chm_pkg::CountW'(held_q);
          ovld_d = 1'b1;
          state_d = chm_pkg::S_IDLE;
        end
      end
      default: state_d = chm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    head_rd <= head_mem[head_ra];
    key_rd  <= key_mem[node_ra];
    val_rd  <= val_mem[node_ra];
    link_rd <= link_mem[node_ra];
    free_rd <= free_mem[free_ra];
    if (head_we) head_mem[head_wa] <= head_wd;
    if (node_we) begin
      key_mem[node_wa] <= key_q;
      val_mem[node_wa] <= val_q;
    end
    if (link_we) link_mem[link_wa] <= link_wd;
    if (free_we) free_mem[free_wa] <= free_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chm_pkg::S_INIT;
      init_q  <= '0;
      bcnt_q  <= CfgW'(256);
      free_q  <= CW'(POOL_SLOTS);
      held_q  <= '0;
      ovld_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      if (cfg_valid_i && cfg_ready_o) bcnt_q <= cfg_data_i;
      free_q  <= free_d;
      held_q  <= held_d;
      ovld_q  <= ovld_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; key_q <= key_d; val_q <= val_d; bkt_q <= bkt_d;
    cur_q <= cur_d; prev_q <= prev_d; tail_q <= tail_d; hit_q <= hit_d;
    hitnx_q <= hitnx_d; alloc_q <= alloc_d; ost_q <= ost_d; oval_q <= oval_d;
    res_st_q <= res_st_d; res_val_q <= res_val_d; res_cnt_q <= res_cnt_d;
  end

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= CW'(POOL_SLOTS)) else $error("free count overflow");
  a_pool_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, free_q} + {1'b0, held_q}) == (CW+1)'(POOL_SLOTS))
    else $error("pool accounting broken");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(found_value_o) && $stable(entry_count_o))
    else $error("result word changed while stalled");
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && status_o == chm_pkg::ST_FULL |-> free_q == '0)
    else $error("full reported with free slots");

endmodule
